// File: hdl/lzss_block_stream_decoder_macros.svh
// Assertion macros used by the LZSS block stream decoder port-level checker.
`ifndef LZSS_BLOCK_STREAM_DECODER_MACROS_SVH
`define LZSS_BLOCK_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define LBSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lbsd assertion failed");

// Next-cycle implication, masked during reset.
`define LBSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lbsd assertion failed");

// Next-cycle implication that also holds across reset.
`define LBSD_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("lbsd reset assertion failed");

`endif

// File: hdl/lbsd_pkg.sv
// Shared types and constants of the LZSS block stream decoder.
package lbsd_pkg;

    localparam int WINDOW_SIZE_DEF  = 4096;
    localparam int MAX_MATCH        = 18;
    localparam int MIN_MATCH        = 3;
    localparam int TOKENS_PER_FLAG  = 8;
    localparam logic [7:0] FILL_BYTE = 8'h20;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        PH_HDR_HI,
        PH_HDR_LO,
        PH_RAW,
        PH_FLAG,
        PH_TOKEN,
        PH_MATCH,
        PH_COPY_RD,
        PH_COPY_WR
    } t_phase;

    typedef struct packed {
        logic load_hdr_hi;
        logic load_len;
        logic block_start;
        logic dec_left;
        logic load_flag;
        logic load_offset;
        logic load_match;
        logic emit_in;
        logic put_in;
        logic next_token;
        logic copy_rd;
        logic copy_wr;
        logic clear_count;
    } t_cmd;

    typedef struct packed {
        logic hdr_zero;
        logic hdr_neg;
        logic left_one;
        logic left_zero;
        logic flag_bit;
        logic tok_one;
        logic copy_one;
        logic out_free;
    } t_status;

endpackage

// File: hdl/lbsd_ctrl.sv
// Parser and copy sequencer of the LZSS block stream decoder.
module lbsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  lbsd_pkg::t_status i_status,
    output logic             o_in_stall,
    output lbsd_pkg::t_cmd   o_cmd
);
    import lbsd_pkg::*;

    t_phase r_phase, n_phase;
    logic   r_halted, n_halted;
    logic   r_last, n_last;
    logic   accepting;
    logic   in_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR_HI;
            r_halted <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_halted <= n_halted;
            r_last   <= n_last;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_halted  = r_halted;
        n_last    = r_last;
        o_cmd     = '0;
        accepting = (r_phase != PH_COPY_RD) && (r_phase != PH_COPY_WR) && i_status.out_free;
        in_fire   = i_in_valid && accepting;
        o_in_stall = !accepting;

        if (in_fire) begin
            if (!r_halted) begin
                unique case (r_phase)
                    PH_HDR_HI: begin
                        o_cmd.load_hdr_hi = 1'b1;
                        n_phase = PH_HDR_LO;
                    end
                    PH_HDR_LO: begin
                        if (i_status.hdr_zero) begin
                            n_halted = 1'b1;
                            n_phase  = PH_HDR_HI;
                        end else begin
                            o_cmd.load_len = 1'b1;
                            if (i_status.hdr_neg) begin
                                n_phase = PH_RAW;
                            end else begin
                                o_cmd.block_start = 1'b1;
                                n_phase = PH_FLAG;
                            end
                        end
                    end
                    PH_RAW: begin
                        o_cmd.emit_in  = 1'b1;
                        o_cmd.dec_left = 1'b1;
                        n_phase = i_status.left_one ? PH_HDR_HI : PH_RAW;
                    end
                    PH_FLAG: begin
                        o_cmd.load_flag = 1'b1;
                        o_cmd.dec_left  = 1'b1;
                        n_phase = i_status.left_one ? PH_HDR_HI : PH_TOKEN;
                    end
                    PH_TOKEN: begin
                        o_cmd.dec_left = 1'b1;
                        if (i_status.flag_bit) begin
                            o_cmd.emit_in    = 1'b1;
                            o_cmd.put_in     = 1'b1;
                            o_cmd.next_token = 1'b1;
                            if (i_status.left_one) begin
                                n_phase = PH_HDR_HI;
                            end else begin
                                n_phase = i_status.tok_one ? PH_FLAG : PH_TOKEN;
                            end
                        end else begin
                            o_cmd.load_offset = 1'b1;
                            n_phase = i_status.left_one ? PH_HDR_HI : PH_MATCH;
                        end
                    end
                    PH_MATCH: begin
                        // start the copy; end-of-stream clearing waits for it
                        o_cmd.dec_left   = 1'b1;
                        o_cmd.load_match = 1'b1;
                        n_last  = i_in_last;
                        n_phase = PH_COPY_RD;
                    end
                    default: begin
                        n_phase = PH_HDR_HI;
                    end
                endcase
            end
            if (i_in_last && !(r_phase == PH_MATCH && !r_halted)) begin
                n_phase  = PH_HDR_HI;
                n_halted = 1'b0;
                o_cmd.clear_count = 1'b1;
            end
        end else if (r_phase == PH_COPY_RD) begin
            o_cmd.copy_rd = 1'b1;
            n_phase = PH_COPY_WR;
        end else if (r_phase == PH_COPY_WR && i_status.out_free) begin
            o_cmd.copy_wr = 1'b1;
            if (i_status.copy_one) begin
                o_cmd.next_token = 1'b1;
                if (i_status.left_zero) begin
                    n_phase = PH_HDR_HI;
                end else begin
                    n_phase = i_status.tok_one ? PH_FLAG : PH_TOKEN;
                end
                if (r_last) begin
                    n_phase  = PH_HDR_HI;
                    n_halted = 1'b0;
                    n_last   = 1'b0;
                    o_cmd.clear_count = 1'b1;
                end
            end else begin
                n_phase = PH_COPY_RD;
            end
        end
    end

endmodule

// File: hdl/lbsd_dp.sv
// Datapath of the LZSS block stream decoder: counters, history window, output word.
module lbsd_dp #(
    parameter int WINDOW_SIZE = lbsd_pkg::WINDOW_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_in_byte,
    input  logic              i_cfg_wr,
    input  logic [31:0]       i_cfg_data,
    input  lbsd_pkg::t_cmd    i_cmd,
    output lbsd_pkg::t_status o_status,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last
);
    import lbsd_pkg::*;

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int FW = AW + 1;
    localparam logic [AW-1:0] POS_START = AW'(WINDOW_SIZE - MAX_MATCH);
    localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_SIZE);

    t_byte       mem [WINDOW_SIZE];

    logic [31:0] r_limit;
    logic [31:0] r_count;
    logic        r_out_valid;
    t_byte       r_out_byte;
    logic        r_out_last;
    logic [AW-1:0] r_pos;
    logic [FW-1:0] r_fill;
    t_byte       r_hdr_hi;
    logic [15:0] r_left;
    t_byte       r_flag;
    logic [3:0]  r_tokens;
    t_byte       r_off_lo;
    logic [AW-1:0] r_src;
    logic [4:0]  r_copy_left;
    t_byte       r_rd_data;
    logic        r_rd_ok;

    logic [15:0] hdr;
    logic        can_emit;
    t_byte       copy_byte;
    logic        wr_en;
    t_byte       wr_data;
    logic        emit_req;
    t_byte       emit_byte;
    logic        emit_last;
    logic [AW-1:0] src_rel;

    assign hdr       = {r_hdr_hi, i_in_byte};
    assign can_emit  = r_count < r_limit;
    assign copy_byte = r_rd_ok ? r_rd_data : FILL_BYTE;
    assign wr_en     = i_cmd.put_in | i_cmd.copy_wr;
    assign wr_data   = i_cmd.copy_wr ? copy_byte : i_in_byte;
    assign emit_req  = i_cmd.emit_in | i_cmd.copy_wr;
    assign emit_byte = i_cmd.copy_wr ? copy_byte : i_in_byte;
    assign emit_last = i_cmd.emit_in || (r_copy_left == 5'd1) || (r_count == r_limit - 32'd1);
    // entries not yet written since the block start read as fill bytes
    assign src_rel   = r_src - POS_START;

    always_comb begin
        o_status.hdr_zero  = (hdr == 16'd0);
        o_status.hdr_neg   = hdr[15];
        o_status.left_one  = (r_left == 16'd1);
        o_status.left_zero = (r_left == 16'd0);
        o_status.flag_bit  = r_flag[0];
        o_status.tok_one   = (r_tokens == 4'd1);
        o_status.copy_one  = (r_copy_left == 5'd1);
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= '1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pos       <= POS_START;
            r_fill      <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (emit_req && can_emit) begin
                r_count <= r_count + 32'd1;
            end
            if (emit_req && can_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.block_start) begin
                r_pos  <= POS_START;
                r_fill <= '0;
            end else if (wr_en) begin
                r_pos <= r_pos + AW'(1);
                if (r_fill != FILL_FULL) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_req && can_emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
        end
        if (i_cmd.load_hdr_hi) begin
            r_hdr_hi <= i_in_byte;
        end
        if (i_cmd.load_len) begin
            r_left <= hdr[15] ? (16'd0 - hdr) : hdr;
        end else if (i_cmd.dec_left) begin
            r_left <= r_left - 16'd1;
        end
        if (i_cmd.load_flag) begin
            r_flag   <= i_in_byte;
            r_tokens <= 4'(TOKENS_PER_FLAG);
        end else if (i_cmd.next_token) begin
            r_flag <= r_flag >> 1;
            if (r_tokens != 4'd0) begin
                r_tokens <= r_tokens - 4'd1;
            end
        end
        if (i_cmd.load_offset) begin
            r_off_lo <= i_in_byte;
        end
        if (i_cmd.load_match) begin
            r_src       <= AW'({i_in_byte[7:4], r_off_lo});
            r_copy_left <= 5'(i_in_byte[3:0]) + 5'(MIN_MATCH);
        end else if (i_cmd.copy_wr) begin
            r_src       <= r_src + AW'(1);
            r_copy_left <= r_copy_left - 5'd1;
        end
        if (i_cmd.copy_rd) begin
            r_rd_ok <= ({1'b0, src_rel} < r_fill);
        end
    end

    // history window: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pos] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_rd) begin
            r_rd_data <= mem[r_src];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// File: hdl/lzss_block_stream_decoder.sv
// Top level of the LZSS block stream decoder.
//
// Usage: packed bytes enter on the input channel (i_in_valid / o_in_stall,
// one word per accepted edge, i_in_last on the final word of a stream).
// Decoded bytes leave on the output channel (o_out_valid / i_out_stall);
// o_out_last marks the final decoded word caused by one input word.
// The output limit is written on the cfg channel (i_cfg_valid / o_cfg_ready,
// ready always high); write it only while the decoder is idle.
// Output: a decoded word is registered and shows on the output in the cycle
// after the input word that makes it; a copied byte is emitted by the window
// write that comes after its registered window read. Header, flag, raw and
// literal words are taken whenever the output word is free. A match takes
// its second byte, then copies each byte (window read, then window write and
// emit), stalling the input; each window read must follow the previous write.
// Reset: the window reads as 0x20 and the write position is 4078. No
// clearing pass is run; a fill count tracks which entries were written since
// the last LZSS block start, so the decoder accepts words right after reset.
// Stall: while the receiver stalls a pending word, the word holds and the
// decoder stalls its input and pauses any copy in progress.
module lzss_block_stream_decoder #(
    parameter int WINDOW_SIZE = lbsd_pkg::WINDOW_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import lbsd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // the limit register takes a write at any edge
    assign o_cfg_ready = 1'b1;

    // controller: parse phase, halt flag, copy sequencing
    lbsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_last),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath: counters, history window, output word
    lbsd_dp #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_byte   (i_in_byte),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

// File: hdl/lbsd_checker.sv
// Port-level checker of the LZSS block stream decoder and its bind.
`include "lzss_block_stream_decoder_macros.svh"

module lbsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_in_byte,
    input logic        i_in_last,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_out_last
);

    // a stalled output word stays valid and unchanged
    `LBSD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `LBSD_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall,
        $stable(o_out_byte) && $stable(o_out_last))
    // a blocked output word backs up into the input channel
    `LBSD_ASSERT_NOW(a_in_backpressure, o_out_valid && i_out_stall, o_in_stall)
    // reset drops any pending output word
    `LBSD_ASSERT_RST(a_reset_idle, !i_rst_n, !o_out_valid)

endmodule

bind lzss_block_stream_decoder lbsd_checker u_lbsd_checker (.*);

// File: tb/lzss_block_stream_decoder_checker.sv
// Checker for the LZSS block stream decoder: predicts decoded words and compares them.
module lzss_block_stream_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import lbsd_pkg::*;

    typedef struct {
        t_byte value;
        logic  last;
    } t_plain_word;

    t_plain_word plain_q[$];

    // Decoder image
    t_byte       hist[WINDOW_SIZE_DEF];
    logic [11:0] wpos;
    t_phase      phase;
    t_byte       hdr_hi;
    logic [15:0] left;
    t_byte       flags;
    logic [3:0]  tokens;
    t_byte       off_lo;
    logic [31:0] emitted;
    logic        halted;
    logic [31:0] out_limit;

    int step_words;
    int fails = 0;
    int checked = 0;

    task automatic clear_parser();
        phase = PH_HDR_HI;
        hdr_hi = '0;
        left = '0;
        flags = '0;
        tokens = '0;
        off_lo = '0;
        emitted = '0;
        halted = 1'b0;
    endtask

    task automatic emit_plain(input t_byte b);
        if (emitted < out_limit) begin
            plain_q.push_back('{value: b, last: 1'b0});
            emitted++;
            step_words++;
        end
    endtask

    task automatic put_window(input t_byte b);
        hist[wpos] = b;
        wpos++;
    endtask

    task automatic advance_token();
        flags = flags >> 1;
        if (tokens != 0)
            tokens--;
        if (left == 0)
            phase = PH_HDR_HI;
        else if (tokens != 0)
            phase = PH_TOKEN;
        else
            phase = PH_FLAG;
    endtask

    task automatic decode_word(input t_byte b, input logic fin);
        logic [15:0] hdr;
        logic [11:0] src;
        int          len;
        t_byte       v;
        step_words = 0;
        if (!halted) begin
            case (phase)
                PH_HDR_HI: begin
                    hdr_hi = b;
                    phase = PH_HDR_LO;
                end
                PH_HDR_LO: begin
                    hdr = {hdr_hi, b};
                    if (hdr == 16'd0) begin
                        halted = 1'b1;
                        phase = PH_HDR_HI;
                    end else if (hdr[15]) begin
                        left = -hdr;
                        phase = PH_RAW;
                    end else begin
                        left = hdr;
                        foreach (hist[i]) hist[i] = FILL_BYTE;
                        wpos = 12'(WINDOW_SIZE_DEF - MAX_MATCH);
                        phase = PH_FLAG;
                    end
                end
                PH_RAW: begin
                    emit_plain(b);
                    left--;
                    if (left == 0)
                        phase = PH_HDR_HI;
                end
                PH_FLAG: begin
                    flags = b;
                    tokens = 4'(TOKENS_PER_FLAG);
                    left--;
                    phase = (left != 0) ? PH_TOKEN : PH_HDR_HI;
                end
                PH_TOKEN: begin
                    left--;
                    if (flags[0]) begin
                        emit_plain(b);
                        put_window(b);
                        advance_token();
                    end else begin
                        off_lo = b;
                        phase = (left != 0) ? PH_MATCH : PH_HDR_HI;
                    end
                end
                PH_MATCH: begin
                    left--;
                    src = {b[7:4], off_lo};
                    len = int'(b[3:0]) + MIN_MATCH;
                    // copy one at a time so overlapping matches see fresh bytes
                    for (int k = 0; k < len; k++) begin
                        v = hist[src];
                        emit_plain(v);
                        put_window(v);
                        src++;
                    end
                    advance_token();
                end
                default: phase = PH_HDR_HI;
            endcase
        end
        if (step_words > 0)
            plain_q[plain_q.size() - 1].last = 1'b1;
        if (fin)
            clear_parser();
    endtask

    always @(posedge i_clk) begin
        t_plain_word exp_w;
        if (!i_rst_n) begin
            plain_q.delete();
            foreach (hist[i]) hist[i] = FILL_BYTE;
            wpos = 12'(WINDOW_SIZE_DEF - MAX_MATCH);
            out_limit = 32'hFFFF_FFFF;
            clear_parser();
        end else begin
            // Compare first, so a word can never match an expectation queued at this edge.
            if (i_out_valid && !i_out_stall) begin
                if (plain_q.size() == 0) begin
                    $error("unexpected decoded word: out_byte %h out_last %b",
                           i_out_byte, i_out_last);
                    fails++;
                end else begin
                    exp_w = plain_q.pop_front();
                    checked++;
                    if (i_out_byte !== exp_w.value) begin
                        $error("out_byte: expected %h, actual %h", exp_w.value, i_out_byte);
                        fails++;
                    end
                    if (i_out_last !== exp_w.last) begin
                        $error("out_last: expected %b, actual %b", exp_w.last, i_out_last);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                out_limit = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                decode_word(i_in_byte, i_in_last);
        end
        o_pending <= plain_q.size();
        o_fail_count <= fails;
        o_checked <= checked;
    end

endmodule

// File: tb/lzss_block_stream_decoder_test.sv
// Testbench top for the LZSS block stream decoder: stimulus, idling and verdict.
module lzss_block_stream_decoder_test;
    import lbsd_pkg::*;

    // Hold off this long after the last expected word so a copy that only
    // drops bytes (output limit reached) can finish before the next write.
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT   = 200000;

    typedef struct {
        t_byte value;
        logic  last;
    } t_pack_word;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    int fail_count;
    int pending;
    int checked;

    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int words_sent = 0;
    int streams = 0;
    int mid_limit;

    t_pack_word pack_q[$];

    lzss_block_stream_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_byte   (in_byte),
        .i_in_last   (in_last),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_byte  (out_byte),
        .o_out_last  (out_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    lzss_block_stream_decoder_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_byte    (in_byte),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_byte   (out_byte),
        .i_out_last   (out_last),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Stall the receiver at random; a zero percentage never stalls.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic push_word(input t_byte b, input logic fin);
        pack_q.push_back('{value: b, last: fin});
    endtask

    // Block headers are big-endian.
    task automatic push_header(input logic [15:0] h);
        push_word(h[15:8], 1'b0);
        push_word(h[7:0], 1'b0);
    endtask

    // Append whole streams until the queue holds about budget words. Most blocks
    // are well-formed LZSS blocks with matches aimed at recently written bytes;
    // the rest are raw blocks, halting headers, cut blocks and trailing junk.
    task automatic build_streams(input int budget);
        t_byte       body[$];
        int          nblocks;
        int          kind;
        int          ntok;
        int          nraw;
        logic        halt_seen;
        logic [11:0] pos;
        logic [11:0] off;
        logic [3:0]  lenn;
        t_byte       flag_b;
        while (pack_q.size() < budget) begin
            nblocks = $urandom_range(1, 3);
            halt_seen = 1'b0;
            for (int k = 0; k < nblocks && !halt_seen; k++) begin
                kind = $urandom_range(0, 99);
                if (kind < 60) begin
                    body.delete();
                    pos = 12'(WINDOW_SIZE_DEF - MAX_MATCH);
                    ntok = $urandom_range(1, 12);
                    for (int t = 0; t < ntok; t++) begin
                        if (t % TOKENS_PER_FLAG == 0) begin
                            flag_b = 8'($urandom);
                            body.push_back(flag_b);
                        end
                        if (flag_b[t % TOKENS_PER_FLAG]) begin
                            body.push_back(8'($urandom));
                            pos++;
                        end else begin
                            if ($urandom_range(0, 3) == 0)
                                off = 12'($urandom);
                            else
                                off = pos - 12'($urandom_range(1, MAX_MATCH));
                            lenn = 4'($urandom);
                            body.push_back(off[7:0]);
                            body.push_back({off[11:8], lenn});
                            pos += 12'(lenn) + 12'(MIN_MATCH);
                        end
                    end
                    // Cut the block short now and then: drops a literal, or leaves a
                    // match offset or a lone flag at the block end.
                    if ($urandom_range(0, 9) == 0)
                        void'(body.pop_back());
                    push_header(16'(body.size()));
                    foreach (body[i]) push_word(body[i], 1'b0);
                end else if (kind < 88) begin
                    nraw = $urandom_range(1, 6);
                    push_header(-16'(nraw));
                    repeat (nraw) push_word(8'($urandom), 1'b0);
                end else begin
                    push_header(16'h0000);
                    repeat ($urandom_range(0, 2)) push_word(8'($urandom), 1'b0);
                    halt_seen = 1'b1;
                end
            end
            // Trailing junk leaves a header or block unfinished at stream end.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) push_word(8'($urandom), 1'b0);
            pack_q[pack_q.size() - 1].last = 1'b1;
            streams++;
        end
    endtask

    // Drain the queue onto the input channel, idling at random between words.
    task automatic send_all();
        t_pack_word w;
        while (pack_q.size() > 0) begin
            w = pack_q.pop_front();
            while ($urandom_range(0, 99) < in_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte <= w.value;
            in_last <= w.last;
            do @(posedge clk); while (in_stall);
            words_sent++;
        end
    endtask

    // Drop valid and wait until every expected word is out, then settle.
    task automatic wait_idle();
        int spin;
        spin = 0;
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
            spin++;
        end while (pending != 0 && spin < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly, receiver heavily.
        in_idle_pct = 24;
        out_idle_pct = 75;

        // Directed: raw block with byte extremes, LZSS block, halt, then short streams.
        push_header(16'hFFFD);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h5A, 1'b0);
        // LZSS: literal, longest match overlapping its own output, literal,
        // shortest match from the blank fill, match offset cut by the block end.
        push_header(16'h0008);
        push_word(8'h05, 1'b0);
        push_word(8'h41, 1'b0);
        push_word(8'hEE, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h80, 1'b0);
        push_word(8'h12, 1'b0);
        // Zero header halts; ignore the rest up to the stream end.
        push_header(16'h0000);
        push_word(8'hAB, 1'b0);
        push_word(8'hCD, 1'b1);
        // Flag byte alone at the block end, closing the stream.
        push_header(16'h0001);
        push_word(8'hFF, 1'b1);
        // Longest raw block, cut off by the stream end.
        push_header(16'h8000);
        push_word(8'h11, 1'b0);
        push_word(8'h22, 1'b1);
        // Longest LZSS block, cut off after one literal.
        push_header(16'h7FFF);
        push_word(8'h01, 1'b0);
        push_word(8'h7E, 1'b1);
        streams += 4;
        send_all();

        // Nothing may come out at a zero limit.
        write_limit(32'd0);
        build_streams(12);
        send_all();

        write_limit(32'd7);
        build_streams(15);
        send_all();

        // Sender idles heavily, receiver lightly.
        in_idle_pct = 75;
        out_idle_pct = 24;
        write_limit(32'hFFFF_FFFF);
        build_streams(22);
        send_all();

        // Full rate on both sides.
        in_idle_pct = 0;
        out_idle_pct = 0;
        mid_limit = $urandom_range(10, 60);
        write_limit(32'(mid_limit));
        build_streams(18);
        send_all();

        wait_idle();
        if (pending != 0)
            $error("%0d decoded words never arrived", pending);

        $display("covered %0d packed words in %0d streams, %0d decoded words compared",
                 words_sent, streams, checked);
        $display("output limits: reset value, 0, 7, all ones and %0d", mid_limit);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/lbsd_pkg.sv
hdl/lbsd_ctrl.sv
hdl/lbsd_dp.sv
hdl/lzss_block_stream_decoder.sv
hdl/lbsd_checker.sv
tb/lzss_block_stream_decoder_checker.sv
tb/lzss_block_stream_decoder_test.sv
